>>> sv/interval_row_packer_unit_macros.svh
// Assertion macros for the file that checks its own logic.
// The checks use the clock clk and the reset arst_n of the module that uses them.
`ifndef INTERVAL_ROW_PACKER_UNIT_MACROS_SVH
`define INTERVAL_ROW_PACKER_UNIT_MACROS_SVH

`define IPK_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define IPK_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ipk_pkg.sv
package ipk_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int DIV_W = 33;
	localparam int DVS_W = 16;

	localparam logic [15:0] BAND_STEP_RST = 16'd100;
	localparam logic [15:0] ROW_GAP_RST = 16'd100;
	localparam logic [15:0] MIN_BAND_W = 16'd10;

	localparam logic REG_BAND_STEP = 1'b0;
	localparam logic REG_ROW_GAP = 1'b1;

	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_POOL = 2'd2;

	typedef struct packed {
		logic signed [31:0] start_pos;
		logic signed [31:0] end_pos;
		logic last_item;
	} item_in_t;

	typedef struct packed {
		logic [6:0] row_index;
		logic [6:0] total_rows;
		logic dropped;
		logic last_result;
	} item_out_t;

	typedef struct packed {
		logic load;
		logic pack_init;
		logic idx_clr;
		logic idx_inc;
		logic item_rd;
		logic band_zero_wr;
		logic div_go;
		logic band_div_wr;
		logic min_clr;
		logic min_upd;
		logic pass_init;
		logic row_clr;
		logic row_rd;
		logic row_eval;
		logic pick_wr;
		logic pass_end;
		logic out_load;
		logic set_done;
	} ipk_cmd_t;

	typedef struct packed {
		logic len_small;
		logic div_done;
		logic idx_last;
		logic min_any;
		logic skip;
		logic used_zero;
		logic row_last;
		logic out_free;
	} ipk_sts_t;

endpackage

>>> sv/ipk_div.sv
module ipk_div (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [ipk_pkg::DIV_W-1:0] dividend,
	input  logic [ipk_pkg::DVS_W-1:0] divisor,
	output logic done,
	output logic [ipk_pkg::DIV_W-1:0] quotient
);
	import ipk_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/ipk_ctrl.sv
module ipk_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  ipk_pkg::ipk_sts_t sts,
	output ipk_pkg::ipk_cmd_t cmd
);
	import ipk_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LEN_RD = 4'd1;
	localparam logic [3:0] S_LEN = 4'd2;
	localparam logic [3:0] S_DIV = 4'd3;
	localparam logic [3:0] S_MIN_RD = 4'd4;
	localparam logic [3:0] S_MIN = 4'd5;
	localparam logic [3:0] S_ITEM_RD = 4'd6;
	localparam logic [3:0] S_ITEM = 4'd7;
	localparam logic [3:0] S_ROW_RD = 4'd8;
	localparam logic [3:0] S_ROW = 4'd9;
	localparam logic [3:0] S_PICK = 4'd10;
	localparam logic [3:0] S_OUT_RD = 4'd11;
	localparam logic [3:0] S_OUT = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.pack_init = 1'b1;
						cmd.idx_clr = 1'b1;
						state_d = S_LEN_RD;
					end
				end
			end
			S_LEN_RD: begin
				cmd.item_rd = 1'b1;
				state_d = S_LEN;
			end
			S_LEN, S_DIV: begin
				if (state_q == S_LEN && !sts.len_small) begin
					cmd.div_go = 1'b1;
					state_d = S_DIV;
				end else if (state_q == S_LEN || sts.div_done) begin
					cmd.band_zero_wr = state_q == S_LEN;
					cmd.band_div_wr = state_q == S_DIV;
					if (sts.idx_last) begin
						cmd.idx_clr = 1'b1;
						cmd.min_clr = 1'b1;
						state_d = S_MIN_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_LEN_RD;
					end
				end
			end
			S_MIN_RD: begin
				cmd.item_rd = 1'b1;
				state_d = S_MIN;
			end
			S_MIN: begin
				cmd.min_upd = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					if (sts.min_any) begin
						cmd.pass_init = 1'b1;
						state_d = S_ITEM_RD;
					end else begin
						state_d = S_OUT_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_MIN_RD;
				end
			end
			S_ITEM_RD: begin
				cmd.item_rd = 1'b1;
				state_d = S_ITEM;
			end
			S_ITEM, S_PICK: begin
				if (state_q == S_ITEM && !sts.skip) begin
					cmd.row_clr = 1'b1;
					state_d = sts.used_zero ? S_PICK : S_ROW_RD;
				end else begin
					cmd.pick_wr = state_q == S_PICK;
					if (sts.idx_last) begin
						cmd.idx_clr = 1'b1;
						cmd.pass_end = 1'b1;
						cmd.min_clr = 1'b1;
						state_d = S_MIN_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_ITEM_RD;
					end
				end
			end
			S_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d = S_ROW;
			end
			S_ROW: begin
				cmd.row_eval = 1'b1;
				state_d = sts.row_last ? S_PICK : S_ROW_RD;
			end
			S_OUT_RD: begin
				cmd.item_rd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.set_done = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/ipk_dp.sv
module ipk_dp #(
	parameter int MAX_ITEMS = ipk_pkg::MAX_ITEMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ipk_pkg::item_in_t in_data,
	input  logic [15:0] band_step,
	input  logic [15:0] row_gap,
	input  ipk_pkg::ipk_cmd_t cmd,
	output ipk_pkg::ipk_sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output ipk_pkg::item_out_t out_data
);
	import ipk_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic signed [31:0] start_mem [MAX_ITEMS];
	logic signed [31:0] end_mem [MAX_ITEMS];
	logic [DIV_W-1:0] band_mem [MAX_ITEMS];
	logic [6:0] irow_mem [MAX_ITEMS];
	logic [1:0] stat_mem [MAX_ITEMS];
	logic signed [32:0] free_mem [MAX_ITEMS];

	logic signed [31:0] start_rd_q;
	logic signed [31:0] end_rd_q;
	logic [DIV_W-1:0] band_rd_q;
	logic [6:0] irow_rd_q;
	logic [1:0] stat_rd_q;
	logic signed [32:0] free_rd_q;

	logic [CW-1:0] cnt_q;
	logic ovf_q;
	logic [IW-1:0] idx_q;
	logic [MAX_ITEMS-1:0] asg_q;
	logic any_q;
	logic [DIV_W-1:0] best_q;
	logic [CW-1:0] used_q;
	logic [IW-1:0] r_q;
	logic hp_q;
	logic hq_q;
	logic [IW-1:0] pick_r_q;
	logic [IW-1:0] pool_r_q;
	logic [6:0] offset_q;
	logic out_valid_q;
	item_out_t out_q;

	logic signed [33:0] len;
	logic signed [33:0] bs34;
	logic [33:0] num;
	logic [15:0] wid;
	logic [DIV_W-1:0] dividend;
	logic [DIV_W-1:0] quot;
	logic div_done;
	logic qual;
	logic [IW-1:0] pick;
	logic row_we;
	logic [IW-1:0] row_wa;
	logic [1:0] row_wst;

	assign len = 34'(end_rd_q) - 34'(start_rd_q) + 34'sd1;
	assign bs34 = $signed({18'd0, band_step});
	assign num = 34'(len - bs34);
	assign wid = (band_step > MIN_BAND_W) ? band_step : MIN_BAND_W;
	assign dividend = DIV_W'(num) + DIV_W'(wid) - DIV_W'(1);

	ipk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(cmd.div_go),
		.dividend(dividend),
		.divisor(wid),
		.done(div_done),
		.quotient(quot)
	);

	assign qual = (stat_rd_q == ST_ACTIVE) && (free_rd_q <= 33'(start_rd_q));
	assign pick = hp_q ? pick_r_q : (hq_q ? pool_r_q : used_q[IW-1:0]);
	assign row_we = cmd.pick_wr || (cmd.row_eval && qual && hp_q);
	assign row_wa = cmd.pick_wr ? pick : r_q;
	assign row_wst = cmd.pick_wr ? ST_ACTIVE : ST_POOL;

	always_comb begin
		sts.len_small = len <= bs34;
		sts.div_done = div_done;
		sts.idx_last = (CW'(idx_q) + CW'(1)) == cnt_q;
		sts.min_any = any_q || !asg_q[idx_q];
		sts.skip = asg_q[idx_q] || (band_rd_q != best_q);
		sts.used_zero = used_q == '0;
		sts.row_last = (CW'(r_q) + CW'(1)) == used_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CW'(MAX_ITEMS))) begin
			start_mem[cnt_q[IW-1:0]] <= in_data.start_pos;
			end_mem[cnt_q[IW-1:0]] <= in_data.end_pos;
		end
		if (cmd.band_zero_wr || cmd.band_div_wr) begin
			band_mem[idx_q] <= cmd.band_zero_wr ? '0 : quot;
		end
		if (cmd.pick_wr) begin
			irow_mem[idx_q] <= 7'(pick) + 7'd1 + offset_q;
			free_mem[pick] <= 33'(end_rd_q) + $signed({17'd0, row_gap});
		end
		if (row_we) begin
			stat_mem[row_wa] <= row_wst;
		end
		if (cmd.item_rd) begin
			start_rd_q <= start_mem[idx_q];
			end_rd_q <= end_mem[idx_q];
			band_rd_q <= band_mem[idx_q];
			irow_rd_q <= irow_mem[idx_q];
		end
		if (cmd.row_rd) begin
			stat_rd_q <= stat_mem[r_q];
			free_rd_q <= free_mem[r_q];
		end
		if (cmd.min_upd && !asg_q[idx_q] && (!any_q || band_rd_q < best_q)) begin
			best_q <= band_rd_q;
		end
		if (cmd.row_eval) begin
			if (qual && !hp_q) begin
				pick_r_q <= r_q;
			end
			if (!qual && stat_rd_q == ST_POOL && !hq_q) begin
				pool_r_q <= r_q;
			end
		end
		if (cmd.out_load) begin
			out_q.row_index <= irow_rd_q;
			out_q.total_rows <= offset_q;
			out_q.dropped <= ovf_q;
			out_q.last_result <= sts.idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			asg_q <= '0;
			any_q <= 1'b0;
			used_q <= '0;
			r_q <= '0;
			hp_q <= 1'b0;
			hq_q <= 1'b0;
			offset_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (cnt_q < CW'(MAX_ITEMS)) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.set_done) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.pack_init) begin
				asg_q <= '0;
				offset_q <= '0;
			end
			if (cmd.pick_wr) begin
				asg_q[idx_q] <= 1'b1;
			end
			if (cmd.min_clr) begin
				any_q <= 1'b0;
			end else if (cmd.min_upd) begin
				any_q <= sts.min_any;
			end
			if (cmd.pass_init) begin
				used_q <= '0;
			end else if (cmd.pick_wr && !hp_q && !hq_q) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.pass_end) begin
				offset_q <= offset_q + 7'(used_q) + {6'd0, (cmd.pick_wr && !hp_q && !hq_q)};
			end
			if (cmd.row_clr) begin
				r_q <= '0;
				hp_q <= 1'b0;
				hq_q <= 1'b0;
			end else if (cmd.row_eval) begin
				r_q <= r_q + IW'(1);
				if (qual) begin
					hp_q <= 1'b1;
				end else if (stat_rd_q == ST_POOL) begin
					hq_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> sv/interval_row_packer_unit.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data (item_in_t)
// out       output     out_valid / out_ready  out_data (item_out_t)
// apb       config     psel / penable         paddr, pwdata, prdata
//
// Items without last_item load one per cycle. Packing finds each item's band, using the
// divider, one quotient bit per cycle, when the item is longer than band_step. Each pass
// finds the lowest band left, then gives each item in it a row after checking the open
// rows; a search that finds no item left ends packing. Results then go out one by one.
// Reset clears all control state; the item and row memories need no clearing.
// A result waiting on out_ready stalls only the output step.
module interval_row_packer_unit #(
	parameter int MAX_ITEMS = ipk_pkg::MAX_ITEMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ipk_pkg::item_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ipk_pkg::item_out_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ipk_pkg::*;

	`include "interval_row_packer_unit_macros.svh"

	logic [15:0] band_step_q;
	logic [15:0] row_gap_q;
	ipk_cmd_t cmd;
	ipk_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_step_q <= BAND_STEP_RST;
			row_gap_q <= ROW_GAP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_BAND_STEP: band_step_q <= pwdata[15:0];
				REG_ROW_GAP: row_gap_q <= pwdata[15:0];
				default: band_step_q <= band_step_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BAND_STEP: prdata = {16'd0, band_step_q};
			REG_ROW_GAP: prdata = {16'd0, row_gap_q};
			default: prdata = '0;
		endcase
	end

	ipk_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_last(in_data.last_item),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	ipk_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.band_step(band_step_q),
		.row_gap(row_gap_q),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	`IPK_CHECK(a_load, in_valid && in_ready, cmd.load, "Accepted item was not loaded.")
	`IPK_CHECK(a_row, out_valid, (out_data.row_index != 7'd0) && (out_data.row_index <= out_data.total_rows), "Row outside the rows used.")
	`IPK_CHECK(a_out, cmd.out_load, sts.out_free, "Result overwritten before it was taken.")
	`IPK_CHECK_NEXT(a_done, cmd.set_done, in_ready, "Block did not return to accepting items.")

endmodule

>>> tb/sv/interval_row_packer_unit_tb.sv
`default_nettype none

module interval_row_packer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipk_pkg::*;

	localparam int CAP = MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	item_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	item_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	interval_row_packer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	logic [15:0] band_step_q = BAND_STEP_RST;
	logic [15:0] row_gap_q = ROW_GAP_RST;
	longint set_start[CAP];
	longint set_end[CAP];
	int set_count = 0;
	bit set_overflow = 0;
	item_out_t rows_expected[$];
	int mismatches = 0;
	longint cycles = 0;
	int hold_cycles = 0;
	bit flow_out = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** interval_row_packer_unit: FAILED **");
			$finish;
		end
	end

	function automatic longint band_index(longint s, longint e);
		longint len, bs, w;
		len = e - s + 1;
		bs = band_step_q;
		w = (bs > MIN_BAND_W) ? bs : MIN_BAND_W;
		if (len <= bs)
			return 0;
		return (len - bs + w - 1) / w;
	endfunction

	task automatic pack_rows();
		int row_of[CAP];
		longint bnd[CAP];
		longint free_at[CAP];
		logic [1:0] status[CAP];
		int offset, used, pick;
		longint best;
		bit any;
		item_out_t r;
		for (int i = 0; i < set_count; i++) begin
			row_of[i] = 0;
			bnd[i] = band_index(set_start[i], set_end[i]);
		end
		offset = 0;
		forever begin
			any = 0;
			best = 0;
			for (int i = 0; i < set_count; i++)
				if (row_of[i] == 0 && (!any || bnd[i] < best)) begin
					best = bnd[i];
					any = 1;
				end
			if (!any)
				break;
			used = 0;
			for (int k = 0; k < CAP; k++)
				status[k] = 2'd0;
			for (int i = 0; i < set_count; i++) begin
				if (row_of[i] != 0 || bnd[i] != best)
					continue;
				pick = -1;
				for (int k = 0; k < used; k++)
					if (status[k] == ST_ACTIVE && free_at[k] <= set_start[i]) begin
						if (pick < 0)
							pick = k;
						else
							status[k] = ST_POOL;
					end
				if (pick < 0)
					for (int k = 0; k < used; k++)
						if (status[k] == ST_POOL) begin
							pick = k;
							break;
						end
				if (pick < 0) begin
					if (used >= CAP)
						continue;
					pick = used;
					used++;
				end
				status[pick] = ST_ACTIVE;
				free_at[pick] = set_end[i] + longint'(row_gap_q);
				row_of[i] = (pick + 1 + offset) & 8'h7f;
			end
			offset = (offset + used) & 8'h7f;
		end
		for (int i = 0; i < set_count; i++) begin
			r.row_index = row_of[i][6:0];
			r.total_rows = offset[6:0];
			r.dropped = set_overflow;
			r.last_result = (i == set_count - 1);
			rows_expected.push_back(r);
		end
		set_count = 0;
		set_overflow = 0;
	endtask

	task automatic send_interval(input logic signed [31:0] s, input logic signed [31:0] e,
		input bit last, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{start_pos: s, end_pos: e, last_item: last};
		do
			@(posedge clk);
		while (!in_ready);
		if (set_count < CAP) begin
			set_start[set_count] = s;
			set_end[set_count] = e;
			set_count++;
		end else
			set_overflow = 1;
		if (last) begin
			pack_rows();
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (rows_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				if (out_data !== rows_expected[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", rows_expected[0], out_data);
				end
				void'(rows_expected.pop_front());
			end
		end
	end

	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (flow_out)
				out_ready <= 1'b1;
			else if (out_ready && out_valid) begin
				gap = $urandom_range(0, 19);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic wait_drained();
		while (rows_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_BAND_STEP)
			band_step_q = v;
		else
			row_gap_q = v;
		@(posedge clk);
	endtask

	function automatic int pick_gap(bit busy);
		return busy ? $urandom_range(0, 19) : 0;
	endfunction

	task automatic random_set(input int n, input int span, input bit busy);
		logic signed [31:0] s, e;
		s = $urandom_range(0, 3) == 0 ? 32'(signed'($urandom)) : -32'sd5000 + $urandom_range(0, 2000);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				e = $urandom;
			else
				e = s + $urandom_range(0, span) - 5;
			send_interval(s, e, i == n - 1, pick_gap(busy));
			if ($urandom_range(0, 9) != 0)
				s = s + $urandom_range(0, span / 2);
		end
	endtask

	task automatic test_directed_extremes();
		send_interval(32'sh80000000, 32'sh7fffffff, 0, 0);
		send_interval(32'sh80000000, 32'sh80000000, 0, 1);
		send_interval(32'sh7fffffff, 32'sh80000000, 0, 0);
		send_interval(0, 99, 0, 0);
		send_interval(0, 100, 0, 0);
		send_interval(50, 149, 0, 2);
		send_interval(199, 298, 0, 0);
		send_interval(200, 210, 0, 0);
		send_interval(32'sh7fffffff, 32'sh7fffffff, 1, 0);
		wait_drained();
		send_interval(5, 5, 1, 0);
		wait_drained();
	endtask

	task automatic test_config_extremes();
		write_reg(REG_BAND_STEP, 16'd0);
		write_reg(REG_ROW_GAP, 16'd0);
		random_set(12, 40, 1);
		wait_drained();
		write_reg(REG_BAND_STEP, 16'hffff);
		write_reg(REG_ROW_GAP, 16'hffff);
		random_set(12, 200000, 1);
		wait_drained();
		write_reg(REG_BAND_STEP, 16'd7);
		write_reg(REG_ROW_GAP, 16'd3);
		random_set(10, 60, 0);
		wait_drained();
	endtask

	task automatic test_overflow_backpressure();
		hold_cycles = 20000;
		random_set(CAP + 3, 30, 0);
		random_set(5, 30, 0);
		wait_drained();
		flow_out = 1;
		random_set(20, 50, 0);
		wait_drained();
		flow_out = 0;
	endtask

	task automatic test_random_sets();
		write_reg(REG_BAND_STEP, 16'd100);
		write_reg(REG_ROW_GAP, 16'd100);
		for (int k = 0; k < 6; k++)
			random_set($urandom_range(1, 12), 300, 1);
		wait_drained();
		write_reg(REG_BAND_STEP, 16'd25);
		write_reg(REG_ROW_GAP, 16'd10);
		for (int k = 0; k < 8; k++)
			random_set($urandom_range(1, 10), 120, k[0]);
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_config_extremes();
		test_overflow_backpressure();
		test_random_sets();
		wait_drained();
		if (mismatches == 0 && rows_expected.size() == 0)
			$display("** interval_row_packer_unit: PASSED **");
		else
			$display("** interval_row_packer_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
